### design/linear_map_transport_6d_top_macros.svh
// assertion helpers for the top-level design file
`ifndef LINEAR_MAP_TRANSPORT_6D_TOP_MACROS_SVH
`define LINEAR_MAP_TRANSPORT_6D_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define LMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LMT_ASSERT_IMP(lbl, ante, cons, msg)
`define LMT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### design/lmt_pkg.sv
package lmt_pkg;

  localparam int unsigned DIM_DEF       = 6;
  localparam int unsigned WORD_BITS_DEF = 48;
  localparam int unsigned FRAC_BITS_DEF = 32;
  localparam int unsigned ACC_BITS_DEF  = 2 * WORD_BITS_DEF - FRAC_BITS_DEF + 4;

  localparam int unsigned FIELD_BITS = 48;
  localparam int unsigned NCOORD     = 6;
  localparam int unsigned MODE_BITS  = 2;
  localparam int unsigned SLOT_BITS  = 6;

  // s_tdata layout
  localparam int unsigned SLOT_LSB     = 0;
  localparam int unsigned VAL_LSB      = SLOT_LSB + SLOT_BITS;
  localparam int unsigned X_LSB        = VAL_LSB + FIELD_BITS;
  localparam int unsigned S_TDATA_RAW  = X_LSB + NCOORD * FIELD_BITS;
  localparam int unsigned S_TDATA_BITS = ((S_TDATA_RAW + 7) / 8) * 8;
  localparam int unsigned M_TDATA_BITS = ((NCOORD * FIELD_BITS + 7) / 8) * 8;

  localparam logic [MODE_BITS-1:0] MODE_LOAD_COEF   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_LOAD_OFFSET = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_TRANSPORT   = 2'd2;

  typedef struct packed {
    logic clear;
    logic issue;
    logic t_we;
    logic k_we;
  } lane_ctl_t;

endpackage

### design/lmt_ram.sv
module lmt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/lmt_lane.sv
module lmt_lane import lmt_pkg::*; #(
  parameter int unsigned DIM       = DIM_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned ACC_BITS  = ACC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lane_ctl_t                   ctl_i,
  input  logic [$clog2(DIM)-1:0]      col_i,
  input  logic signed [WORD_BITS-1:0] x_i,
  input  logic [$clog2(DIM)-1:0]      wr_col_i,
  input  logic signed [WORD_BITS-1:0] wr_data_i,
  output logic signed [ACC_BITS-1:0]  acc_o,
  output logic                        busy_o
);

  localparam int unsigned LO_BITS   = WORD_BITS / 2;
  localparam int unsigned HI_BITS   = WORD_BITS - LO_BITS;
  localparam int unsigned PLL_BITS  = 2 * LO_BITS + 1;
  localparam int unsigned PMID_BITS = WORD_BITS + 1;
  localparam int unsigned PHH_BITS  = 2 * HI_BITS;
  localparam int unsigned PROD_BITS = 2 * WORD_BITS;

  logic [WORD_BITS-1:0]         rdata;
  logic [DIM-1:0]               t_vld_q;
  logic signed [WORD_BITS-1:0]  k_q;
  logic                         v1_q, v2_q, v3_q;
  logic                         cvld_q;
  logic signed [WORD_BITS-1:0]  x1_q;
  logic signed [WORD_BITS-1:0]  coef;
  logic signed [PLL_BITS-1:0]   pll_d, pll_q;
  logic signed [PMID_BITS-1:0]  plh_d, plh_q;
  logic signed [PMID_BITS-1:0]  phl_d, phl_q;
  logic signed [PHH_BITS-1:0]   phh_d, phh_q;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [PROD_BITS-1:0]  prod_sh;
  logic signed [ACC_BITS-1:0]   term_d, term_q;
  logic signed [ACC_BITS-1:0]   acc_d, acc_q;

  // one matrix row per lane
  lmt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DIM)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.t_we),
    .waddr_i (wr_col_i),
    .wdata_i (wr_data_i),
    .raddr_i (col_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= '0;
      k_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      if (ctl_i.t_we) begin
        t_vld_q[wr_col_i] <= 1'b1;
      end
      if (ctl_i.k_we) begin
        k_q <= wr_data_i;
      end
      v1_q <= ctl_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // split multiply: four half-word partial products, low halves unsigned
  always_comb begin
    coef  = cvld_q ? $signed(rdata) : '0;
    pll_d = PLL_BITS'($signed({1'b0, coef[LO_BITS-1:0]}))
          * PLL_BITS'($signed({1'b0, x1_q[LO_BITS-1:0]}));
    plh_d = PMID_BITS'($signed({1'b0, coef[LO_BITS-1:0]}))
          * PMID_BITS'($signed(x1_q[WORD_BITS-1:LO_BITS]));
    phl_d = PMID_BITS'($signed(coef[WORD_BITS-1:LO_BITS]))
          * PMID_BITS'($signed({1'b0, x1_q[LO_BITS-1:0]}));
    phh_d = PHH_BITS'($signed(coef[WORD_BITS-1:LO_BITS]))
          * PHH_BITS'($signed(x1_q[WORD_BITS-1:LO_BITS]));
    prod    = (PROD_BITS'(phh_q) <<< (2 * LO_BITS))
            + ((PROD_BITS'(plh_q) + PROD_BITS'(phl_q)) <<< LO_BITS)
            + PROD_BITS'(pll_q);
    prod_sh = prod >>> FRAC_BITS;
    term_d  = ACC_BITS'(prod_sh);
    acc_d   = acc_q;
    if (ctl_i.clear) begin
      acc_d = ACC_BITS'(k_q);
    end else if (v3_q) begin
      acc_d = acc_q + term_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      x1_q   <= x_i;
      cvld_q <= t_vld_q[col_i];
    end
    pll_q  <= pll_d;
    plh_q  <= plh_d;
    phl_q  <= phl_d;
    phh_q  <= phh_d;
    term_q <= term_d;
    acc_q  <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = v1_q | v2_q | v3_q;

endmodule

### design/lmt_merge.sv
module lmt_merge import lmt_pkg::*; #(
  parameter int unsigned DIM       = DIM_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned ACC_BITS  = ACC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cap_i,
  input  logic signed [ACC_BITS-1:0] acc_i [DIM],
  output logic                       free_o,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [M_TDATA_BITS-1:0]    m_tdata_o,
  output logic                       m_tuser_o
);

  localparam int unsigned TOP_BITS = ACC_BITS - WORD_BITS + 1;

  logic signed [WORD_BITS-1:0] sat_w [DIM];
  logic                        flag_d;
  logic [TOP_BITS-1:0]         top_bits;
  logic [M_TDATA_BITS-1:0]     data_d, data_q;
  logic                        user_q;
  logic                        valid_q;

  // clamp each lane sum to the word range
  always_comb begin
    flag_d   = 1'b0;
    top_bits = '0;
    for (int j = 0; j < DIM; j++) begin
      top_bits = acc_i[j][ACC_BITS-1:WORD_BITS-1];
      if ((&top_bits) || !(|top_bits)) begin
        sat_w[j] = acc_i[j][WORD_BITS-1:0];
      end else begin
        flag_d = 1'b1;
        if (acc_i[j][ACC_BITS-1]) begin
          sat_w[j] = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
          sat_w[j] = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
      end
    end
  end

  for (genvar i = 0; i < NCOORD; i++) begin : g_field
    if (i < DIM) begin : g_used
      assign data_d[i*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(sat_w[i]);
    end else begin : g_zero
      assign data_d[i*FIELD_BITS +: FIELD_BITS] = '0;
    end
  end
  if (M_TDATA_BITS > NCOORD * FIELD_BITS) begin : g_pad
    assign data_d[M_TDATA_BITS-1:NCOORD*FIELD_BITS] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cap_i) begin
      valid_q <= 1'b1;
    end else if (m_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      data_q <= data_d;
      user_q <= flag_d;
    end
  end

  assign free_o     = !valid_q || m_tready_i;
  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = user_q;

endmodule

### design/linear_map_transport_6d_top.sv
// linear map transport: result = T * x + K on a DIM-coordinate vector, signed fixed point
// s_axis: tuser carries the mode, tdata the slot, load value and six coordinates
// load requests (coefficient or offset) give no result
// a transport request gives one result on m_axis; tuser flags clamping
// DIM row lanes each multiply-accumulate one matrix column per cycle
// each lane: registered row read, split multiply, shift, accumulate (4-stage pipe)
// result valid once the column sweep ends, the lane pipes drain and the output register is free
// a new transport is taken only after the last one is captured; loads every cycle while idle
// s_tready is high only while no transport is in flight
// a held result in the output register does not block new requests; the lanes
// wait with the next sum until the output register is free
// reset clears the matrix (valid bit per entry), the offsets and all handshakes
`include "linear_map_transport_6d_top_macros.svh"

module linear_map_transport_6d_top import lmt_pkg::*; #(
  parameter int unsigned DIM       = DIM_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  output logic                    s_tready_o,
  // slot, load_value, in_x, in_xp, in_y, in_yp, in_z, in_dp, zero pad
  input  logic [S_TDATA_BITS-1:0] s_tdata_i,
  // mode
  input  logic [MODE_BITS-1:0]    s_tuser_i,
  output logic                    m_tvalid_o,
  input  logic                    m_tready_i,
  // out_x, out_xp, out_y, out_yp, out_z, out_dp
  output logic [M_TDATA_BITS-1:0] m_tdata_o,
  // saturated
  output logic                    m_tuser_o
);

  localparam int unsigned SH_BITS  = 2 * WORD_BITS - FRAC_BITS;
  localparam int unsigned ACC_BITS = ((SH_BITS > WORD_BITS) ? SH_BITS : WORD_BITS) + 4;
  localparam int unsigned CW       = $clog2(DIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        in_acc;
  logic                        xfer_acc;
  logic                        cap;
  logic                        out_free;
  logic [DIM-1:0]              busy;
  logic                        lane_busy;
  logic [MODE_BITS-1:0]        mode;
  logic [SLOT_BITS-1:0]        slot;
  logic signed [FIELD_BITS-1:0] load_field;
  logic signed [WORD_BITS-1:0] load_word;
  logic [CW-1:0]               slot_row, slot_col;
  logic                        coef_ok, off_ok;
  logic signed [WORD_BITS-1:0] x_q [DIM];
  logic signed [ACC_BITS-1:0]  acc [DIM];
  lane_ctl_t                   ctl [DIM];

  assign mode       = s_tuser_i;
  assign slot       = s_tdata_i[SLOT_LSB +: SLOT_BITS];
  assign load_field = s_tdata_i[VAL_LSB +: FIELD_BITS];
  assign load_word  = WORD_BITS'(load_field);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign xfer_acc   = in_acc && (mode == MODE_TRANSPORT);
  assign lane_busy  = |busy;
  assign cap        = (state_q == ST_DRAIN) && !lane_busy && out_free;
  assign s_tready_o = (state_q == ST_IDLE);

  // slot split into row and column
  always_comb begin
    slot_row = '0;
    for (int r = 1; r < DIM; r++) begin
      if (int'(slot) >= r * DIM) begin
        slot_row = CW'(r);
      end
    end
    slot_col = CW'(int'(slot) - int'(slot_row) * DIM);
    coef_ok  = in_acc && (mode == MODE_LOAD_COEF) && (int'(slot) < DIM * DIM);
    off_ok   = in_acc && (mode == MODE_LOAD_OFFSET) && (int'(slot) < DIM);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (xfer_acc) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        if (cnt_q == CW'(DIM - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cap) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  for (genvar l = 0; l < DIM; l++) begin : g_x
    always_ff @(posedge clk_i) begin
      if (xfer_acc) begin
        if (l < NCOORD) begin
          x_q[l] <= WORD_BITS'($signed(s_tdata_i[X_LSB + (l % NCOORD) * FIELD_BITS +: FIELD_BITS]));
        end else begin
          x_q[l] <= '0;
        end
      end
    end
  end

  for (genvar j = 0; j < DIM; j++) begin : g_lane
    always_comb begin
      ctl[j].clear = xfer_acc;
      ctl[j].issue = (state_q == ST_RUN);
      ctl[j].t_we  = coef_ok && (slot_row == CW'(j));
      ctl[j].k_we  = off_ok && (int'(slot) == j);
    end

    lmt_lane #(
      .DIM       (DIM),
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .ACC_BITS  (ACC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl[j]),
      .col_i     (cnt_q),
      .x_i       (x_q[cnt_q]),
      .wr_col_i  (slot_col),
      .wr_data_i (load_word),
      .acc_o     (acc[j]),
      .busy_o    (busy[j])
    );
  end

  lmt_merge #(
    .DIM       (DIM),
    .WORD_BITS (WORD_BITS),
    .ACC_BITS  (ACC_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_i      (cap),
    .acc_i      (acc),
    .free_o     (out_free),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  `LMT_ASSERT_NXT(a_xfer_starts, xfer_acc, (state_q == ST_RUN) && (cnt_q == '0), "transport did not start at column zero")
  `LMT_ASSERT_NXT(a_run_ends, (state_q == ST_RUN) && (cnt_q == CW'(DIM - 1)), state_q == ST_DRAIN, "lane sweep overran")
  `LMT_ASSERT_IMP(a_idle_empty, s_tready_o, !lane_busy, "lane pipe busy while idle")
  `LMT_ASSERT_IMP(a_out_source, $rose(m_tvalid_o), $past(state_q) == ST_DRAIN, "result raised outside drain")

endmodule
